// ===== hdl/tsa_pkg.sv =====
package tsa_pkg;

  // Data widths
  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 40;
  localparam int COEF_W  = 42;   // Q.40 signed coefficients, c(0) = 1.0
  localparam int ACC_W   = 50;   // Horner accumulator, |acc| stays below 2^48
  localparam int Y_W     = 64;   // x*x kept exactly (Q6.56)
  localparam int MOP_W   = 33;   // multiplier operand: one 32-bit chunk plus sign
  localparam int PP_W    = 2 * MOP_W;
  localparam int PROD_W  = 116;  // partial product accumulator
  localparam int Y_SHIFT = 56;
  localparam int OUT_SHIFT = 40;

  localparam logic signed [SINE_W-1:0] SINE_MAX = {1'b0, {(SINE_W-1){1'b1}}};
  localparam logic signed [SINE_W-1:0] SINE_MIN = {1'b1, {(SINE_W-1){1'b0}}};

  // Step addresses of the sequencer program
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_SQ   = 4'd1;
  localparam logic [PC_W-1:0] PC_SQW  = 4'd2;
  localparam logic [PC_W-1:0] PC_H0   = 4'd3;
  localparam logic [PC_W-1:0] PC_H1   = 4'd4;
  localparam logic [PC_W-1:0] PC_H2   = 4'd5;
  localparam logic [PC_W-1:0] PC_H3   = 4'd6;
  localparam logic [PC_W-1:0] PC_H4   = 4'd7;
  localparam logic [PC_W-1:0] PC_H5   = 4'd8;
  localparam logic [PC_W-1:0] PC_F0   = 4'd9;
  localparam logic [PC_W-1:0] PC_F1   = 4'd10;
  localparam logic [PC_W-1:0] PC_F2   = 4'd11;
  localparam logic [PC_W-1:0] PC_FO   = 4'd12;

  // Multiplier operand A select
  localparam logic [1:0] MA_X      = 2'd0;
  localparam logic [1:0] MA_ACC_LO = 2'd1;
  localparam logic [1:0] MA_ACC_HI = 2'd2;

  // Multiplier operand B select
  localparam logic [1:0] MB_X    = 2'd0;
  localparam logic [1:0] MB_Y_LO = 2'd1;
  localparam logic [1:0] MB_Y_HI = 2'd2;

  // Product accumulator operation
  localparam logic [1:0] P_HOLD  = 2'd0;
  localparam logic [1:0] P_LOAD  = 2'd1;
  localparam logic [1:0] P_ADD32 = 2'd2;
  localparam logic [1:0] P_ADD64 = 2'd3;

  // Register write-back
  localparam logic [1:0] WB_NONE = 2'd0;
  localparam logic [1:0] WB_Y    = 2'd1;
  localparam logic [1:0] WB_ACC  = 2'd2;

  // Sequencing
  localparam logic [2:0] SQ_NEXT  = 3'd0;
  localparam logic [2:0] SQ_JUMP  = 3'd1;
  localparam logic [2:0] SQ_START = 3'd2;
  localparam logic [2:0] SQ_KZERO = 3'd3;
  localparam logic [2:0] SQ_LOOP  = 3'd4;
  localparam logic [2:0] SQ_EMIT  = 3'd5;

  typedef struct packed {
    logic [1:0]      mul_a;
    logic [1:0]      mul_b;
    logic [1:0]      prod_op;
    logic [1:0]      wb;
    logic [2:0]      seq;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t uw(logic [1:0] a, logic [1:0] b, logic [1:0] p,
                                logic [1:0] w, logic [2:0] s, logic [PC_W-1:0] t);
    uword_t u;
    u.mul_a   = a;
    u.mul_b   = b;
    u.prod_op = p;
    u.wb      = w;
    u.seq     = s;
    u.target  = t;
    return u;
  endfunction

  // Program store: one control word per step
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      PC_IDLE: u = uw(MA_X,      MB_X,    P_HOLD,  WB_NONE, SQ_START, PC_SQ);
      PC_SQ:   u = uw(MA_X,      MB_X,    P_HOLD,  WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_SQW:  u = uw(MA_X,      MB_X,    P_HOLD,  WB_Y,    SQ_KZERO, PC_F0);
      PC_H0:   u = uw(MA_ACC_LO, MB_Y_LO, P_HOLD,  WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_H1:   u = uw(MA_ACC_LO, MB_Y_HI, P_LOAD,  WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_H2:   u = uw(MA_ACC_HI, MB_Y_LO, P_ADD32, WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_H3:   u = uw(MA_ACC_HI, MB_Y_HI, P_ADD32, WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_H4:   u = uw(MA_X,      MB_X,    P_ADD64, WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_H5:   u = uw(MA_X,      MB_X,    P_HOLD,  WB_ACC,  SQ_LOOP,  PC_H0);
      PC_F0:   u = uw(MA_ACC_LO, MB_X,    P_HOLD,  WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_F1:   u = uw(MA_ACC_HI, MB_X,    P_LOAD,  WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_F2:   u = uw(MA_X,      MB_X,    P_ADD32, WB_NONE, SQ_NEXT,  PC_IDLE);
      PC_FO:   u = uw(MA_X,      MB_X,    P_HOLD,  WB_NONE, SQ_EMIT,  PC_IDLE);
      default: u = uw(MA_X,      MB_X,    P_HOLD,  WB_NONE, SQ_JUMP,  PC_IDLE);
    endcase
    return u;
  endfunction

  // (-1)^k * round(2^40 / (2k+1)!), zero once below half an LSB
  function automatic logic signed [COEF_W-1:0] coef(logic [3:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      4'd0:    c =  42'sd1099511627776;
      4'd1:    c = -42'sd183251937963;
      4'd2:    c =  42'sd9162596898;
      4'd3:    c = -42'sd218157069;
      4'd4:    c =  42'sd3029959;
      4'd5:    c = -42'sd27545;
      4'd6:    c =  42'sd177;
      4'd7:    c = -42'sd1;
      default: c =  42'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/taylor_sine_approximator_top.sv =====
// Channel   | Direction | Payload                                  | Handshake
// s_axis    | in        | tdata[31:0] angle (Q3.28)                 | tvalid/tready
// m_axis    | out       | tdata[39:0] sine_value (Q11.28),          | tvalid/tready
//           |           | tuser[0] overflow                        |
// cfg       | in        | cfg_wdata[3:0] term_count                 | cfg_wen, no wait
//
// An angle request is taken only in the idle step; the sequencer then forms x*x, runs one
// Horner step per term beyond the first (N = clamped term count) and multiplies by x; it
// ends one request before taking the next. All of it uses the one 33x33 multiplier that a
// microcoded sequencer shares: x*x, four partial products per Horner step, two for acc*x.
// Reset (rst, synchronous) returns the sequencer to idle, empties the output
// register and sets term_count to 6. The result waits in an output register, so
// the next request is taken while an earlier result is still stalled downstream;
// the sequencer holds on its last step only if that register is still full.
module taylor_sine_approximator_top #(
  parameter int MAX_TERMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [39:0] sine_value
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata       // term_count
);

  localparam int K_W = $clog2(MAX_TERMS + 1);

  // Configuration
  logic [3:0] term_count;

  // Sequencer
  logic [tsa_pkg::PC_W-1:0] pc;
  logic [tsa_pkg::PC_W-1:0] pc_next;
  tsa_pkg::uword_t          uw;

  // Datapath
  logic signed [tsa_pkg::ANGLE_W-1:0] x;
  logic [tsa_pkg::Y_W-1:0]            y;
  logic signed [tsa_pkg::ACC_W-1:0]   acc;
  logic [K_W-1:0]                     k;
  logic signed [tsa_pkg::MOP_W-1:0]   ma;
  logic signed [tsa_pkg::MOP_W-1:0]   mb;
  logic signed [tsa_pkg::PP_W-1:0]    pp;
  logic signed [tsa_pkg::PROD_W-1:0]  pp_ext;
  logic signed [tsa_pkg::PROD_W-1:0]  prod;

  logic                               in_acc;
  logic                               out_free;
  logic [K_W-1:0]                     n_terms;
  logic signed [tsa_pkg::COEF_W-1:0]  c_load;
  logic signed [tsa_pkg::COEF_W-1:0]  c_step;
  logic                               fits;
  logic signed [tsa_pkg::SINE_W-1:0]  sine_sat;

  assign uw            = tsa_pkg::ucode(pc);
  assign s_axis_tready = (pc == tsa_pkg::PC_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Clamp the term count to what the coefficient table serves
  assign n_terms = (term_count > 4'(MAX_TERMS)) ? K_W'(MAX_TERMS) : K_W'(term_count);
  assign c_load  = tsa_pkg::coef(4'(n_terms - 1'b1));
  assign c_step  = tsa_pkg::coef(4'(k - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= 4'd6;
    end else if (cfg_wen) begin
      term_count <= cfg_wdata;
    end
  end

  // Step counter with conditional jumps
  always_comb begin
    pc_next = pc + 1'b1;
    case (uw.seq)
      tsa_pkg::SQ_NEXT:  pc_next = pc + 1'b1;
      tsa_pkg::SQ_JUMP:  pc_next = uw.target;
      tsa_pkg::SQ_START: pc_next = in_acc ? uw.target : pc;
      tsa_pkg::SQ_KZERO: pc_next = (k == '0) ? uw.target : pc + 1'b1;
      tsa_pkg::SQ_LOOP:  pc_next = (k != K_W'(1)) ? uw.target : pc + 1'b1;
      tsa_pkg::SQ_EMIT:  pc_next = out_free ? uw.target : pc;
      default:           pc_next = tsa_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tsa_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Shared multiplier: 33x33 signed, product registered
  always_comb begin
    case (uw.mul_a)
      tsa_pkg::MA_ACC_LO: ma = {1'b0, acc[31:0]};
      tsa_pkg::MA_ACC_HI: ma = {{(tsa_pkg::MOP_W-(tsa_pkg::ACC_W-32)){acc[tsa_pkg::ACC_W-1]}},
                                acc[tsa_pkg::ACC_W-1:32]};
      default:            ma = {x[tsa_pkg::ANGLE_W-1], x};
    endcase
    case (uw.mul_b)
      tsa_pkg::MB_Y_LO: mb = {1'b0, y[31:0]};
      tsa_pkg::MB_Y_HI: mb = {1'b0, y[63:32]};
      default:          mb = {x[tsa_pkg::ANGLE_W-1], x};
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= ma * mb;
  end

  assign pp_ext = {{(tsa_pkg::PROD_W-tsa_pkg::PP_W){pp[tsa_pkg::PP_W-1]}}, pp};

  // Partial product accumulator
  always_ff @(posedge clk) begin
    case (uw.prod_op)
      tsa_pkg::P_LOAD:  prod <= pp_ext;
      tsa_pkg::P_ADD32: prod <= prod + (pp_ext <<< 32);
      tsa_pkg::P_ADD64: prod <= prod + (pp_ext <<< 64);
      default:          prod <= prod;
    endcase
  end

  // Operand registers: load on acceptance, write back as the program says
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x <= s_axis_tdata;
      if (n_terms == '0) begin
        k   <= '0;
        acc <= '0;
      end else begin
        k   <= n_terms - 1'b1;
        acc <= {{(tsa_pkg::ACC_W-tsa_pkg::COEF_W){c_load[tsa_pkg::COEF_W-1]}}, c_load};
      end
    end else begin
      case (uw.wb)
        tsa_pkg::WB_Y: begin
          y <= pp[tsa_pkg::Y_W-1:0];
        end
        tsa_pkg::WB_ACC: begin
          // acc = c(k-1) + floor(acc*y / 2^56)
          acc <= {{(tsa_pkg::ACC_W-tsa_pkg::COEF_W){c_step[tsa_pkg::COEF_W-1]}}, c_step}
                 + prod[tsa_pkg::Y_SHIFT+tsa_pkg::ACC_W-1:tsa_pkg::Y_SHIFT];
          k   <= k - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Take floor(acc*x / 2^40) and saturate to 40 signed bits
  localparam int TOP_LO = tsa_pkg::OUT_SHIFT + tsa_pkg::SINE_W - 1;
  assign fits = (prod[tsa_pkg::PROD_W-1:TOP_LO] == '0)
             || (prod[tsa_pkg::PROD_W-1:TOP_LO] == '1);
  assign sine_sat = fits ? prod[TOP_LO:tsa_pkg::OUT_SHIFT]
                  : (prod[tsa_pkg::PROD_W-1] ? tsa_pkg::SINE_MIN : tsa_pkg::SINE_MAX);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (uw.seq == tsa_pkg::SQ_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.seq == tsa_pkg::SQ_EMIT && out_free) begin
      m_axis_tdata    <= sine_sat;
      m_axis_tuser[0] <= !fits;
    end
  end

  // Checks
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (pc == tsa_pkg::PC_SQ))
    else $error("accepted request did not start the program");

  a_k_range : assert property (@(posedge clk) disable iff (rst)
    (pc != tsa_pkg::PC_IDLE) |-> (k < K_W'(MAX_TERMS)))
    else $error("term index beyond table");

  a_valid_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(pc) == tsa_pkg::PC_FO))
    else $error("result raised outside the emit step");

  a_ovf_saturates : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == tsa_pkg::SINE_MAX || m_axis_tdata == tsa_pkg::SINE_MIN))
    else $error("overflow without saturated value");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TERMS     = 8;
  localparam int DIRECT_LIMIT  = 25;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 86;
  // Settling time after the drain; allow a comfortable margin.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int CYCLE_LIMIT   = 1000000;

  // pi and pi/2 in Q3.28
  localparam logic [31:0] ANGLE_PI      = 32'h3243F6A9;
  localparam logic [31:0] ANGLE_HALF_PI = 32'h1921FB54;
  localparam logic [31:0] ANGLE_ONE     = 32'h10000000;

  localparam logic signed [63:0] SINE_TOP    = 64'sd549755813887;
  localparam logic signed [63:0] SINE_BOTTOM = -64'sd549755813888;
  localparam logic [63:0]        COEF_ONE    = 64'd1 << tsa_pkg::OUT_SHIFT;
  localparam logic [63:0]        FACT_CAP    = 64'd1 << (tsa_pkg::OUT_SHIFT + 2);

  typedef struct packed {
    logic                       ovf;
    logic [tsa_pkg::SINE_W-1:0] sine;
  } sine_result_t;

  // One row of the directed table: the term count to run it under, the angle,
  // and a hand-written result where one is obvious.
  typedef struct packed {
    logic [3:0]   terms;
    logic [31:0]  angle;
    logic         typed;
    sine_result_t fixed;
  } angle_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] angle
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [39:0] sine_value
  logic [0:0]  m_axis_tuser;   // [0] overflow
  logic        cfg_wen;
  logic [3:0]  cfg_wdata;      // term_count

  sine_result_t sine_expected_q [$];
  angle_row_t   direct_rows [$];
  logic [3:0]   term_count_now;
  int           fail_count;
  int           burst_left;
  int           cycle_count;
  int           rx_hold;
  bit           tx_steady;
  bit           rx_steady;

  taylor_sine_approximator_top #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Series coefficient k in Q.40: (-1)^k * round(2^40 / (2k+1)!). Stop growing
  // the factorial once it passes 2^42, where the rounded value is surely zero.
  function automatic logic signed [63:0] taylor_coef(input int k);
    logic [63:0] fact;
    logic [63:0] mag;
    int          i;
    fact = 64'd1;
    for (i = 2; i <= 2 * k + 1 && fact <= FACT_CAP; i++) begin
      fact = fact * i;
    end
    mag = (fact > FACT_CAP) ? 64'd0 : (COEF_ONE + fact / 2) / fact;
    return (k % 2 == 1) ? -$signed(mag) : $signed(mag);
  endfunction

  // Horner evaluation of the truncated series, with x*x kept exact and every
  // product floored by an arithmetic shift of the full-width product.
  function automatic sine_result_t predict_sine(input logic [3:0] terms,
                                                input logic [31:0] angle);
    sine_result_t       res;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] acc;
    logic signed [63:0] r;
    logic signed [127:0] prod;
    int                 n;
    int                 k;
    x = {{32{angle[31]}}, angle};
    n = (terms > MAX_TERMS) ? MAX_TERMS : terms;
    r = '0;
    if (n > 0) begin
      y   = x * x;
      acc = taylor_coef(n - 1);
      for (k = n - 1; k > 0; k--) begin
        prod = acc * y;
        acc  = taylor_coef(k - 1) + $signed(prod[tsa_pkg::Y_SHIFT +: 64]);
      end
      prod = acc * x;
      r    = $signed(prod[tsa_pkg::OUT_SHIFT +: 64]);
    end
    res.ovf = 1'b0;
    if (r > SINE_TOP) begin
      r       = SINE_TOP;
      res.ovf = 1'b1;
    end else if (r < SINE_BOTTOM) begin
      r       = SINE_BOTTOM;
      res.ovf = 1'b1;
    end
    res.sine = r[tsa_pkg::SINE_W-1:0];
    return res;
  endfunction

  function automatic angle_row_t mk_row(input logic [3:0] terms, input logic [31:0] angle,
                                        input logic typed, input logic [39:0] sine);
    angle_row_t row;
    row.terms      = terms;
    row.angle      = angle;
    row.typed      = typed;
    row.fixed.sine = sine;
    row.fixed.ovf  = 1'b0;
    return row;
  endfunction

  // Mix of angle shapes: raw bit patterns, the useful range of about one
  // half-turn either way, tiny values, values hugging both ends of the range
  // and whole radians.
  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = $urandom;
      4, 5, 6:    a = $urandom_range(0, 2 * ANGLE_PI) - ANGLE_PI;
      7:          a = $urandom_range(0, 131071) - 32'd65536;
      8:          a = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 4095)
                                           : 32'h80000000 + $urandom_range(0, 4095);
      default: begin
        a        = '0;
        a[31:28] = 4'($urandom_range(0, 15));
      end
    endcase
    return a;
  endfunction

  // Offer one angle request. Bursts of back-to-back requests are separated by
  // random gaps; a steady phase never drops tvalid between requests. Only drop
  // tvalid when the gap is real, so it is never lowered and raised in one step.
  task automatic send_angle(input logic [31:0] angle, input sine_result_t want);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angle;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    sine_expected_q.push_back(want);
  endtask

  // Drop the request line, wait for every outstanding result, then let the
  // sequencer settle so the block is truly idle.
  task automatic wait_drained();
    int waited;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    waited     = 0;
    while (sine_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sine_expected_q.size() != 0) begin
      $error("%0d sine results never arrived", sine_expected_q.size());
      fail_count++;
      sine_expected_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change term_count only with the block idle; the write lands at the next edge.
  task automatic set_term_count(input logic [3:0] terms);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= terms;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    term_count_now = terms;
  endtask

  // Receiver: stall in runs of random length, or stay ready throughout in a
  // steady phase.
  always @(posedge clk) begin
    if (rx_steady) begin
      rx_hold = 0;
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      rx_hold = $urandom_range(0, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each delivered result against the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    sine_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sine_expected_q.size() == 0) begin
        $error("sine result %h with no request outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        want = sine_expected_q.pop_front();
        if (m_axis_tdata !== want.sine) begin
          $error("sine_value: expected %h, got %h", want.sine, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    angle_row_t   row;
    sine_result_t want;
    logic [3:0]   plan_terms;
    logic [31:0]  angle;
    int           r;
    int           p;
    int           i;

    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    fail_count     = 0;
    burst_left     = 0;
    cycle_count    = 0;
    rx_hold        = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    term_count_now = 4'd6;   // value after reset

    // Directed table. Rows with six terms run before any write, so they see
    // the reset setting. Saturation is out of reach for a 32-bit angle, yet the
    // overflow flag is still compared on every result.
    direct_rows.push_back(mk_row(4'd6, 32'h00000000, 1'b1, 40'h0));
    direct_rows.push_back(mk_row(4'd6, 32'h7FFFFFFF, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd6, 32'h80000000, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd6, ANGLE_HALF_PI, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd6, -ANGLE_HALF_PI, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd6, 32'h00000001, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd6, 32'hFFFFFFFF, 1'b0, 40'h0));
    // Zero terms: the empty sum, whatever the angle.
    direct_rows.push_back(mk_row(4'd0, 32'h7FFFFFFF, 1'b1, 40'h0));
    direct_rows.push_back(mk_row(4'd0, 32'h80000000, 1'b1, 40'h0));
    // One term: sin(x) ~ x, so the angle comes back sign-extended.
    direct_rows.push_back(mk_row(4'd1, 32'h7FFFFFFF, 1'b1, 40'h007FFFFFFF));
    direct_rows.push_back(mk_row(4'd1, 32'h80000000, 1'b1, 40'hFF80000000));
    direct_rows.push_back(mk_row(4'd1, ANGLE_ONE, 1'b1, 40'h0010000000));
    direct_rows.push_back(mk_row(4'd1, 32'hFFFFFFFF, 1'b1, 40'hFFFFFFFFFF));
    // Full series, counts above the maximum, which clamp, and two partial series.
    direct_rows.push_back(mk_row(4'd8, 32'h7FFFFFFF, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd8, 32'h80000000, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd8, ANGLE_PI, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd15, 32'h7FFFFFFF, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd15, 32'h80000000, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd15, ANGLE_HALF_PI, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd2, ANGLE_ONE, 1'b0, 40'h0));
    direct_rows.push_back(mk_row(4'd7, 32'hC0000000, 1'b0, 40'h0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table; change term_count between groups of rows.
    for (r = 0; r < direct_rows.size() && r < DIRECT_LIMIT; r++) begin
      row = direct_rows[r];
      if (row.terms != term_count_now) set_term_count(row.terms);
      want = row.typed ? row.fixed : predict_sine(term_count_now, row.angle);
      send_angle(row.angle, want);
    end

    // Random phases: the extremes of term_count first, then five terms, then random settings.
    // Every fourth phase runs with no idling on either side.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       plan_terms = 4'd8;
        1:       plan_terms = 4'd15;
        2:       plan_terms = 4'd1;
        3:       plan_terms = 4'd0;
        4:       plan_terms = 4'd5;
        default: plan_terms = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 8));
      endcase
      set_term_count(plan_terms);
      tx_steady = (p % 4 == 2);
      rx_steady = (p % 4 == 2);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        angle = random_angle();
        send_angle(angle, predict_sine(term_count_now, angle));
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
